>>> design/rau_pkg.sv
// rau_pkg: shared types, codes and widths of the rational arithmetic unit.
// No dependencies.
package rau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int W2         = 2 * DATA_WIDTH;
    localparam int CW         = $clog2(W2);
    localparam int QDEPTH     = 2;

    // operation codes
    localparam logic [2:0] FN_NORM = 3'd0;
    localparam logic [2:0] FN_ADD  = 3'd1;
    localparam logic [2:0] FN_SUB  = 3'd2;
    localparam logic [2:0] FN_MUL  = 3'd3;
    localparam logic [2:0] FN_DIV  = 3'd4;
    localparam logic [2:0] FN_LESS = 3'd5;
    localparam logic [2:0] FN_EQ   = 3'd6;
    localparam logic [2:0] FN_NONE = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // job classes decided by the front end
    localparam logic [1:0] KIND_RUN  = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] lhs_num;
        logic signed [31:0] lhs_den;
        logic signed [31:0] rhs_num;
        logic signed [31:0] rhs_den;
    } t_req;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               cmp_true;
        logic [1:0]         status;
    } t_res;

    // classified job: operands in sign-magnitude form
    typedef struct packed {
        logic [2:0]            func;
        logic [1:0]            kind;
        logic                  a_neg;
        logic [DATA_WIDTH-1:0] a_num;
        logic [DATA_WIDTH-1:0] a_den;
        logic                  b_neg;
        logic [DATA_WIDTH-1:0] b_num;
        logic [DATA_WIDTH-1:0] b_den;
    } t_job;

endpackage

>>> design/rau_front.sv
// rau_front: accepts requests, converts operands to sign-magnitude,
// classifies them and holds them in a short job queue. Uses rau_pkg.
module rau_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rau_pkg::t_req i_req,
    output logic          busy,
    input  logic          i_pop,
    output logic          o_job_valid,
    output rau_pkg::t_job o_job
);
    import rau_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_job                  r_q [QDEPTH];
    logic [PW-1:0]         r_wr, r_rd;
    logic [PW:0]           r_cnt;
    t_job                  n_job;
    logic [DATA_WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
    logic                  push;

    function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
        mag = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        an_m = mag(i_req.lhs_num[DATA_WIDTH-1:0]);
        ad_m = mag(i_req.lhs_den[DATA_WIDTH-1:0]);
        bn_m = mag(i_req.rhs_num[DATA_WIDTH-1:0]);
        bd_m = mag(i_req.rhs_den[DATA_WIDTH-1:0]);
        n_job.func  = i_req.func;
        n_job.a_num = an_m;
        n_job.a_den = ad_m;
        n_job.b_num = bn_m;
        n_job.b_den = bd_m;
        n_job.a_neg = (i_req.lhs_num[DATA_WIDTH-1] ^ i_req.lhs_den[DATA_WIDTH-1])
                      && (an_m != '0);
        n_job.b_neg = (i_req.rhs_num[DATA_WIDTH-1] ^ i_req.rhs_den[DATA_WIDTH-1])
                      && (bn_m != '0);
        if (i_req.func == FN_NONE) begin
            n_job.kind = KIND_ZERO;
        end else if (ad_m == '0 || (i_req.func != FN_NORM && bd_m == '0)) begin
            n_job.kind = KIND_ERR;
        end else begin
            n_job.kind = KIND_RUN;
        end
    end

    assign busy        = (r_cnt == (PW+1)'(QDEPTH));
    assign push        = start && !busy;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(QDEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QDEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QDEPTH)) else $error("job queue count above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0) else $error("pop from empty job queue");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("job queue count lost a push");

endmodule

>>> design/rau_back.sv
// rau_back: executes queued jobs: cross products on one shared multiplier,
// binary GCD, restoring division and result packing. Uses rau_pkg.
module rau_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  rau_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_done,
    output rau_pkg::t_res o_res
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_COMB = 4'd4;
    localparam logic [3:0] S_GSH  = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam logic [W2-1:0] LIMIT = W2'(1) << (DATA_WIDTH - 1);

    logic [3:0]    r_state, n_state;
    t_job          r_job, n_jobr;
    logic [W2-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [W2-1:0] r_n, r_d, r_ga, r_gb, n_n, n_d, n_ga, n_gb;
    logic [W2-1:0] r_rn, r_rdm, n_rn, n_rdm;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    t_res          r_res, n_res;

    logic [DATA_WIDTH-1:0] mul_a, mul_b;
    logic [W2-1:0]         prod;
    logic [W2-1:0]         c_n, c_d;
    logic                  c_neg, c_sb, c_cmp;
    logic [W2:0]           sh_n, sh_d;
    logic [DATA_WIDTH-1:0] num_w;

    function automatic t_res pack(input logic signed [31:0] num, input logic [30:0] den,
                                  input logic cmp, input logic [1:0] st);
        t_res r;
        r.res_num  = num;
        r.res_den  = den;
        r.cmp_true = cmp;
        r.status   = st;
        pack = r;
    endfunction

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_M0: begin
                mul_a = r_job.a_num;
                mul_b = (r_job.func == FN_MUL) ? r_job.b_num : r_job.b_den;
            end
            S_M1: begin
                mul_a = r_job.b_num;
                mul_b = r_job.a_den;
            end
            default: begin
                mul_a = r_job.a_den;
                mul_b = r_job.b_den;
            end
        endcase
        prod = W2'(mul_a) * W2'(mul_b);
    end

    // combine products into numerator / denominator
    always_comb begin
        c_sb  = (r_job.func == FN_SUB) ? ~r_job.b_neg : r_job.b_neg;
        c_n   = r_x;
        c_d   = r_z;
        c_neg = r_job.a_neg ^ r_job.b_neg;
        case (r_job.func)
            FN_NORM: begin
                c_n   = W2'(r_job.a_num);
                c_d   = W2'(r_job.a_den);
                c_neg = r_job.a_neg;
            end
            FN_ADD, FN_SUB: begin
                if (r_job.a_neg == c_sb) begin
                    c_n   = r_x + r_y;
                    c_neg = r_job.a_neg;
                end else if (r_x >= r_y) begin
                    c_n   = r_x - r_y;
                    c_neg = r_job.a_neg;
                end else begin
                    c_n   = r_y - r_x;
                    c_neg = c_sb;
                end
                if (c_n == '0) begin
                    c_neg = 1'b0;
                end
            end
            FN_DIV: begin
                c_d = r_y;
            end
            default: begin
            end
        endcase
        if (r_job.func == FN_EQ) begin
            c_cmp = (r_job.a_neg == r_job.b_neg) && (r_x == r_y);
        end else if (r_job.a_neg != r_job.b_neg) begin
            c_cmp = r_job.a_neg;
        end else begin
            c_cmp = r_job.a_neg ? (r_x > r_y) : (r_x < r_y);
        end
        sh_n  = {r_rn, r_n[W2-1]};
        sh_d  = {r_rdm, r_d[W2-1]};
        num_w = r_neg ? (~r_n[DATA_WIDTH-1:0] + 1'b1) : r_n[DATA_WIDTH-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_jobr  = r_job;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_n     = r_n;
        n_d     = r_d;
        n_ga    = r_ga;
        n_gb    = r_gb;
        n_rn    = r_rn;
        n_rdm   = r_rdm;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_res   = r_res;
        o_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop  = 1'b1;
                    n_jobr = i_job;
                    if (i_job.kind == KIND_ZERO) begin
                        n_done = 1'b1;
                        n_res  = pack(32'sd0, 31'd1, 1'b0, ST_OK);
                    end else if (i_job.kind == KIND_ERR) begin
                        n_done = 1'b1;
                        n_res  = pack(32'sd0, 31'd1, 1'b0, ST_ZDEN);
                    end else if (i_job.func == FN_NORM) begin
                        n_state = S_COMB;
                    end else begin
                        n_state = S_M0;
                    end
                end
            end
            S_M0: begin
                n_x     = prod;
                n_state = S_M1;
            end
            S_M1: begin
                n_y     = prod;
                n_state = (r_job.func == FN_LESS || r_job.func == FN_EQ) ? S_COMB : S_M2;
            end
            S_M2: begin
                n_z     = prod;
                n_state = S_COMB;
            end
            S_COMB: begin
                n_state = S_IDLE;
                if (r_job.func == FN_LESS || r_job.func == FN_EQ) begin
                    n_done = 1'b1;
                    n_res  = pack(32'sd0, 31'd1, c_cmp, ST_OK);
                end else if (c_d == '0) begin
                    n_done = 1'b1;
                    n_res  = pack(32'sd0, 31'd1, 1'b0, ST_ZDEN);
                end else if (c_n == '0) begin
                    n_done = 1'b1;
                    n_res  = pack(32'sd0, 31'd1, 1'b0, ST_OK);
                end else begin
                    n_n     = c_n;
                    n_d     = c_d;
                    n_ga    = c_n;
                    n_gb    = c_d;
                    n_neg   = c_neg;
                    n_state = S_GSH;
                end
            end
            S_GSH: begin
                // shared factors of two come straight off n and d
                if (!r_ga[0] && !r_gb[0]) begin
                    n_ga = r_ga >> 1;
                    n_gb = r_gb >> 1;
                    n_n  = r_n >> 1;
                    n_d  = r_d >> 1;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_ga == r_gb) begin
                    n_rn    = '0;
                    n_rdm   = '0;
                    n_cnt   = '0;
                    n_state = (r_ga == W2'(1)) ? S_FIN : S_DIV;
                end else if (!r_ga[0]) begin
                    n_ga = r_ga >> 1;
                end else if (!r_gb[0]) begin
                    n_gb = r_gb >> 1;
                end else if (r_ga > r_gb) begin
                    n_ga = r_ga - r_gb;
                end else begin
                    n_gb = r_gb - r_ga;
                end
            end
            S_DIV: begin
                // one quotient bit of n/g and d/g per cycle
                if (sh_n >= {1'b0, r_ga}) begin
                    n_rn = W2'(sh_n - {1'b0, r_ga});
                    n_n  = {r_n[W2-2:0], 1'b1};
                end else begin
                    n_rn = sh_n[W2-1:0];
                    n_n  = {r_n[W2-2:0], 1'b0};
                end
                if (sh_d >= {1'b0, r_ga}) begin
                    n_rdm = W2'(sh_d - {1'b0, r_ga});
                    n_d   = {r_d[W2-2:0], 1'b1};
                end else begin
                    n_rdm = sh_d[W2-1:0];
                    n_d   = {r_d[W2-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W2-1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_d > LIMIT - 1'b1 || r_n > (r_neg ? LIMIT : LIMIT - 1'b1)) begin
                    n_res = pack(32'sd0, 31'd1, 1'b0, ST_OVF);
                end else begin
                    n_res = pack(32'(signed'(num_w)), 31'(r_d[DATA_WIDTH-2:0]),
                                 1'b0, ST_OK);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_jobr;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_n   <= n_n;
        r_d   <= n_d;
        r_ga  <= n_ga;
        r_gb  <= n_gb;
        r_rn  <= n_rn;
        r_rdm <= n_rdm;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.status != ST_OK) |-> (r_res.res_num == 0 && r_res.res_den == 31'd1))
        else $error("error result not 0/1");
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD || r_state == S_DIV) |-> (r_ga != '0 && r_gb != '0))
        else $error("gcd operand reached zero");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.cmp_true) |-> r_res.res_num == 0)
        else $error("compare result carries a value");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE) else $error("job taken while busy");

endmodule

>>> design/rational_arith_unit.sv
// rational_arith_unit: top level of the exact fraction arithmetic unit.
// Depends on rau_pkg, rau_front and rau_back.
//
//  channel   | ports                  | handshake
//  ----------+------------------------+-------------------------------------
//  request   | i_req (t_req)          | taken when start=1 and busy=0
//  result    | o_res (t_res)          | o_done high one cycle, cannot stall
//
// Back-end steps per request, from the pop: early-out codes (unused code, zero
// denominator) finish at the pop, compares run products and combine, and
// arithmetic adds GCD steps (shared twos plus binary GCD), then 64 division
// steps when the odd part of the GCD exceeds 1, then packing. o_done rises in
// the cycle after the last step. Reset (synchronous, active low) empties the
// 2-entry job queue and idles the back end. busy rises only when it is full.
module rational_arith_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rau_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output rau_pkg::t_res o_res
);
    import rau_pkg::*;

    logic job_valid;
    logic job_pop;
    t_job job;

    // front end: operand sign/magnitude split, early-out classification
    rau_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .i_pop       (job_pop),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // back end: products, GCD reduction, result packing
    rau_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (job_pop),
        .o_done      (o_done),
        .o_res       (o_res)
    );

endmodule

>>> sim/rational_arith_unit_tb.sv
// rational_arith_unit_tb: self-checking bench for the fraction arithmetic unit.
// Depends on rau_pkg and rational_arith_unit; predicts each result in place.
`timescale 1ns / 100ps

module rational_arith_unit_tb;
    import rau_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    rational_arith_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .o_done(o_done), .o_res(o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req pending_reqs[$];
    t_res expected_fracs[$];
    int   mismatches = 0;
    int   idle_pct = 0;
    bit   feed_done = 1'b0;
    longint cycle_count = 0;

    // sign-magnitude split of a two's complement fraction
    function automatic void split_frac(input logic signed [31:0] n,
                                       input logic signed [31:0] d,
                                       output bit neg, output logic [63:0] mn,
                                       output logic [63:0] md);
        longint sn, sd;
        sn = n;
        sd = d;
        mn = (sn < 0) ? -sn : sn;
        md = (sd < 0) ? -sd : sd;
        neg = ((sn < 0) != (sd < 0)) && (mn != 0);
    endfunction

    function automatic logic [63:0] euclid_gcd(input logic [63:0] a,
                                               input logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_res predict_frac(input t_req r);
        t_res o;
        bit an, bn, neg, bx;
        logic [63:0] anum, aden, bnum, bden, n, d, x, y, g;
        o = '{res_num: 32'sd0, res_den: 31'd1, cmp_true: 1'b0, status: ST_OK};
        split_frac(r.lhs_num, r.lhs_den, an, anum, aden);
        split_frac(r.rhs_num, r.rhs_den, bn, bnum, bden);
        neg = 1'b0;
        n = 0;
        d = 1;
        if (r.func == FN_NONE) return o;
        if (aden == 0 || (r.func != FN_NORM && bden == 0)) begin
            o.status = ST_ZDEN;
            return o;
        end
        if (r.func == FN_LESS || r.func == FN_EQ) begin
            x = anum * bden;
            y = bnum * aden;
            if (r.func == FN_EQ) o.cmp_true = (an == bn) && (x == y);
            else if (an != bn) o.cmp_true = an;
            else o.cmp_true = an ? (x > y) : (x < y);
            return o;
        end
        case (r.func)
            FN_NORM: begin
                neg = an; n = anum; d = aden;
            end
            FN_ADD, FN_SUB: begin
                x = anum * bden;
                y = bnum * aden;
                bx = (r.func == FN_SUB) ? !bn : bn;
                if (an == bx) begin
                    n = x + y; neg = an;
                end else if (x >= y) begin
                    n = x - y; neg = an;
                end else begin
                    n = y - x; neg = bx;
                end
                if (n == 0) neg = 1'b0;
                // subtracting zero keeps the left sign
                if (r.func == FN_SUB && bnum == 0) neg = (n != 0) && an;
                d = aden * bden;
            end
            FN_MUL: begin
                neg = an != bn; n = anum * bnum; d = aden * bden;
            end
            default: begin
                neg = an != bn; n = anum * bden; d = aden * bnum;
            end
        endcase
        if (d == 0) begin
            o.status = ST_ZDEN;
            return o;
        end
        if (n == 0) return o;
        g = euclid_gcd(n, d);
        n = n / g;
        d = d / g;
        if (d > 64'h7FFF_FFFF || n > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            o.status = ST_OVF;
            return o;
        end
        o.res_num = neg ? -n[31:0] : n[31:0];
        o.res_den = d[30:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input t_res got, input t_res want);
        mismatches++;
        $display("mismatch %s: got %0d/%0d c%0d s%0d want %0d/%0d c%0d s%0d", what,
                 got.res_num, got.res_den, got.cmp_true, got.status,
                 want.res_num, want.res_den, want.cmp_true, want.status);
    endtask

    // driver: at most one nonblocking write to start per edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_fracs.insert(expected_fracs.size(), predict_frac(i_req));
                void'(pending_reqs.pop_front());
            end
            if ((!start || !busy) && pending_reqs.size() > 0) begin
                if ($urandom_range(99) >= idle_pct) begin
                    start <= 1'b1;
                    i_req <= pending_reqs[0];
                end else begin
                    start <= 1'b0;
                end
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be stalled
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_fracs.size() == 0) begin
                report_mismatch("unexpected", o_res, '0);
            end else begin
                t_res want;
                want = expected_fracs.pop_front();
                if (o_res.res_num !== want.res_num) report_mismatch("res_num", o_res, want);
                if (o_res.res_den !== want.res_den) report_mismatch("res_den", o_res, want);
                if (o_res.cmp_true !== want.cmp_true) report_mismatch("cmp_true", o_res, want);
                if (o_res.status !== want.status) report_mismatch("status", o_res, want);
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(20) - 10;
            5, 6: return $urandom_range(2000) - 1000;
            7: return $urandom_range(65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input logic [2:0] f, input logic [31:0] an,
                           input logic [31:0] ad, input logic [31:0] bn,
                           input logic [31:0] bd);
        t_req r;
        r.func = f; r.lhs_num = an; r.lhs_den = ad; r.rhs_num = bn; r.rhs_den = bd;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || start) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed corners
        add_req(FN_NORM, 6, -4, 0, 0);
        add_req(FN_NORM, 32'h8000_0000, 1, 5, 5);
        add_req(FN_NORM, 32'h8000_0000, -1, 0, 1);
        add_req(FN_NORM, 0, -7, 1, 1);
        add_req(FN_NORM, 3, 0, 1, 1);
        add_req(FN_NORM, 0, 0, 1, 1);
        add_req(FN_ADD, 1, 2, 1, 3);
        add_req(FN_ADD, 32'h7FFF_FFFF, 1, 1, 1);
        add_req(FN_ADD, 1, 2, 1, 0);
        add_req(FN_SUB, 1, 2, 1, 2);
        add_req(FN_SUB, -5, 3, 0, 7);
        add_req(FN_SUB, 32'h8000_0000, 1, 0, -1);
        add_req(FN_MUL, 32'h8000_0000, 1, -1, 1);
        add_req(FN_MUL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_req(FN_MUL, 0, 5, 3, -4);
        add_req(FN_DIV, 3, 4, 0, 5);
        add_req(FN_DIV, 3, 4, -9, 8);
        add_req(FN_DIV, 1, 32'h8000_0000, 1, 1);
        add_req(FN_LESS, -1, 2, 1, 3);
        add_req(FN_LESS, 1, -2, -1, 3);
        add_req(FN_LESS, 1, 2, 2, 4);
        add_req(FN_EQ, 1, 2, -2, -4);
        add_req(FN_EQ, 0, 3, 0, -5);
        add_req(FN_EQ, 1, 0, 1, 1);
        add_req(FN_NONE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 48;
                2: idle_pct = 21;
                default: idle_pct = 0;
            endcase
            for (int k = 0; k < 475; k++)
                add_req($urandom_range(7), pick_word(), pick_word(),
                        pick_word(), pick_word());
            drain();
        end
        feed_done = 1'b1;
    end

    initial begin
        wait (feed_done);
        while (expected_fracs.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_fracs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        wait (cycle_count > 1500000);
        $display("FAILED: results differ");
        $finish;
    end
endmodule

>>> filelist.f
design/rau_pkg.sv
design/rau_front.sv
design/rau_back.sv
design/rational_arith_unit.sv
sim/rational_arith_unit_tb.sv
